// File: rtl/l4pxs_pkg.sv
package l4pxs_pkg;

    localparam int KEY_WORDS          = 4;
    localparam int KEY_WORD_W         = 64;
    localparam int KEY_BYTES          = 32;
    localparam int KEY_IDX_W          = $clog2(KEY_BYTES);
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W  = 2;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 2'd3;

    localparam logic [KEY_WORD_W-1:0] KEY_WORD0_RST = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_WORD_W-1:0] KEY_WORD1_RST = 64'hFEDC_BA98_7654_3210;
    localparam logic [KEY_WORD_W-1:0] KEY_WORD2_RST = 64'h0011_2233_4455_6677;
    localparam logic [KEY_WORD_W-1:0] KEY_WORD3_RST = 64'h8899_AABB_CCDD_EEFF;

    localparam logic [7:0] ETH_P_IP_HIGH = 8'h08;
    localparam logic [7:0] ETH_P_IP_LOW  = 8'h00;
    localparam logic [7:0] PROTO_NUM_TCP = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP = 8'd17;
    localparam logic [3:0] MIN_IHL       = 4'd5;

    localparam int START_W = 7;
    localparam int END_W   = 17;

    localparam logic [START_W-1:0] ETH_HDR_BYTES = 7'd14;
    localparam logic [START_W-1:0] TCP_HDR_BYTES = 7'd20;
    localparam logic [START_W-1:0] UDP_HDR_BYTES = 7'd8;

    localparam int POS_TYPE_HIGH = 12;
    localparam int POS_TYPE_LOW  = 13;
    localparam int POS_IHL       = 14;
    localparam int POS_LEN_HIGH  = 16;
    localparam int POS_LEN_LOW   = 17;
    localparam int POS_PROTO     = 23;

    typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] t_key;

    typedef struct packed {
        logic                 scramble;
        logic [KEY_IDX_W-1:0] key_idx;
    } t_ctl;

    function automatic logic [7:0] key_byte(input t_key key, input logic [KEY_IDX_W-1:0] idx);
        logic [KEY_WORD_W-1:0] word;
        logic [5:0]            shift;
        word  = key[idx[KEY_IDX_W-1:3]];
        shift = {~idx[2:0], 3'b000};
        return word[shift +: 8];
    endfunction

endpackage

// File: rtl/l4pxs_key_regs.sv
module l4pxs_key_regs
    import l4pxs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [KEY_WORD_W-1:0]  i_data,
    output t_key                   o_key
);

    t_key r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_WORD0_RST;
            r_key[1] <= KEY_WORD1_RST;
            r_key[2] <= KEY_WORD2_RST;
            r_key[3] <= KEY_WORD3_RST;
        end else if (i_wr) begin
            unique case (i_index)
                REG_KEY_WORD0: r_key[0] <= i_data;
                REG_KEY_WORD1: r_key[1] <= i_data;
                REG_KEY_WORD2: r_key[2] <= i_data;
                REG_KEY_WORD3: r_key[3] <= i_data;
            endcase
        end
    end

    assign o_key = r_key;

endmodule

// File: rtl/l4pxs_hdr_track.sv
module l4pxs_hdr_track
    import l4pxs_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_flen,
    input  logic        i_last,
    output t_ctl        o_ctl
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic [7:0]                r_type_high, n_type_high, c_type_high;
    logic                      r_is_ipv4, n_is_ipv4, c_is_ipv4;
    logic [3:0]                r_hdr_words, n_hdr_words, c_hdr_words;
    logic [15:0]               r_ip_len, n_ip_len, c_ip_len;
    logic [START_W-1:0]        r_pl_start, n_pl_start, c_pl_start;
    logic [END_W-1:0]          r_pl_end, n_pl_end, c_pl_end;
    logic                      r_enabled, n_enabled, c_enabled;

    logic               l4_known;
    logic [START_W-1:0] l4_bytes;
    logic [START_W-1:0] hdr_bytes;
    logic [END_W-1:0]   ip_end;
    logic               decide_ok;

    always_comb begin
        l4_known = 1'b1;
        l4_bytes = TCP_HDR_BYTES;
        if (i_byte == PROTO_NUM_TCP) begin
            l4_bytes = TCP_HDR_BYTES;
        end else if (i_byte == PROTO_NUM_UDP) begin
            l4_bytes = UDP_HDR_BYTES;
        end else begin
            l4_known = 1'b0;
        end
        hdr_bytes = START_W'({r_hdr_words, 2'b00}) + l4_bytes;
        ip_end    = END_W'(ETH_HDR_BYTES) + END_W'(r_ip_len);
        decide_ok = r_is_ipv4 && (r_hdr_words >= MIN_IHL) && l4_known
                    && (r_ip_len >= 16'(hdr_bytes)) && (ip_end <= END_W'(i_flen));
    end

    always_comb begin
        c_type_high = r_type_high;
        c_is_ipv4   = r_is_ipv4;
        c_hdr_words = r_hdr_words;
        c_ip_len    = r_ip_len;
        c_pl_start  = r_pl_start;
        c_pl_end    = r_pl_end;
        c_enabled   = r_enabled;
        case (r_pos)
            POSITION_WIDTH'(POS_TYPE_HIGH): c_type_high = i_byte;
            POSITION_WIDTH'(POS_TYPE_LOW): begin
                c_is_ipv4 = (r_type_high == ETH_P_IP_HIGH) && (i_byte == ETH_P_IP_LOW);
            end
            POSITION_WIDTH'(POS_IHL): c_hdr_words = i_byte[3:0];
            POSITION_WIDTH'(POS_LEN_HIGH): c_ip_len = {i_byte, 8'h00};
            POSITION_WIDTH'(POS_LEN_LOW): c_ip_len = {r_ip_len[15:8], i_byte};
            POSITION_WIDTH'(POS_PROTO): begin
                c_enabled = decide_ok;
                if (decide_ok) begin
                    c_pl_start = ETH_HDR_BYTES + hdr_bytes;
                    c_pl_end   = ip_end;
                end
            end
            default: ;
        endcase

        o_ctl.scramble = c_enabled && (r_pos != POS_MAX)
                         && (END_W'(r_pos) >= END_W'(c_pl_start))
                         && (END_W'(r_pos) < c_pl_end);
        o_ctl.key_idx  = r_pos[KEY_IDX_W-1:0] - c_pl_start[KEY_IDX_W-1:0];

        if (i_last) begin
            n_pos       = '0;
            n_type_high = '0;
            n_is_ipv4   = 1'b0;
            n_hdr_words = '0;
            n_ip_len    = '0;
            n_pl_start  = '0;
            n_pl_end    = '0;
            n_enabled   = 1'b0;
        end else begin
            n_pos       = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
            n_type_high = c_type_high;
            n_is_ipv4   = c_is_ipv4;
            n_hdr_words = c_hdr_words;
            n_ip_len    = c_ip_len;
            n_pl_start  = c_pl_start;
            n_pl_end    = c_pl_end;
            n_enabled   = c_enabled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_type_high <= '0;
            r_is_ipv4   <= 1'b0;
            r_hdr_words <= '0;
            r_ip_len    <= '0;
            r_pl_start  <= '0;
            r_pl_end    <= '0;
            r_enabled   <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_type_high <= n_type_high;
            r_is_ipv4   <= n_is_ipv4;
            r_hdr_words <= n_hdr_words;
            r_ip_len    <= n_ip_len;
            r_pl_start  <= n_pl_start;
            r_pl_end    <= n_pl_end;
            r_enabled   <= n_enabled;
        end
    end

endmodule

// File: rtl/l4_payload_xor_scrambler.sv
// Scrambles the TCP or UDP payload of Ethernet/IPv4 frames streamed one byte per item with a
// repeating 32-byte key held in four 64-bit registers, passing every other byte through
// unchanged and flagging scrambled bytes on m_axis_tuser. An item passes an input register and
// then a result register, and the block sustains one byte per cycle unless the output side's
// tready is low; a new item is taken whenever the result register is empty or being drained.
// Key registers are written through the configuration channel, which is always ready; the user
// must write them only between frames, which the block itself does not enforce.
module l4_payload_xor_scrambler
    import l4pxs_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // frame_byte [7:0], frame_length [23:8]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte [7:0]
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser,   // out_scrambled [0]
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [KEY_WORD_W-1:0]  i_cfg_data
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic [15:0] r_in_flen;
    logic        r_in_last;

    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_scr;

    logic advance;
    logic step;
    t_key key;
    t_ctl ctl;

    assign advance       = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    l4pxs_key_regs u_key_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_key   (key)
    );

    l4pxs_hdr_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_hdr_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_flen  (r_in_flen),
        .i_last  (r_in_last),
        .o_ctl   (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_flen <= s_axis_tdata[23:8];
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
        if (step) begin
            r_out_byte <= ctl.scramble ? (r_in_byte ^ key_byte(key, ctl.key_idx)) : r_in_byte;
            r_out_last <= r_in_last;
            r_out_scr  <= ctl.scramble;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_scr;

endmodule

// File: rtl/l4pxs_checker.sv
module l4pxs_protocol_checker
    import l4pxs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // An empty result register must never hold back the input side.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while no result is pending");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result presented straight after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind l4_payload_xor_scrambler l4pxs_protocol_checker u_l4pxs_protocol_checker (.*);

// File: tb/sv/l4pxs_checker.sv
`timescale 1ns / 1ps

module l4pxs_checker
    import l4pxs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // frame_byte [7:0], frame_length [23:8]
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte [7:0]
    input  logic                   m_axis_tlast,
    input  logic                   m_axis_tuser,   // out_scrambled [0]
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [KEY_WORD_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_scrambled
);

    localparam int                  POS_W   = POSITION_WIDTH_DEF;
    localparam logic [POS_W-1:0]    POS_MAX = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       scrambled;
    } t_scrambled_byte;

    t_scrambled_byte       expected_bytes[$];
    logic [KEY_WORD_W-1:0] key_words[KEY_WORDS];

    logic [POS_W-1:0] frame_pos;
    logic [7:0]       type_high;
    logic             is_ipv4;
    logic [3:0]       header_words;
    logic [15:0]      total_length;
    logic [16:0]      payload_start;
    logic [16:0]      payload_end;
    logic             scramble_on;

    int mismatches;
    int checked;
    int scrambled;

    function automatic void clear_frame_state();
        frame_pos     = '0;
        type_high     = '0;
        is_ipv4       = 1'b0;
        header_words  = '0;
        total_length  = '0;
        payload_start = '0;
        payload_end   = '0;
        scramble_on   = 1'b0;
    endfunction

    function automatic t_scrambled_byte predict_out_byte(input logic [7:0] b,
                                                         input logic [15:0] flen,
                                                         input logic last);
        t_scrambled_byte res;
        logic [16:0]     pos17;
        logic [16:0]     l4_len;
        logic [16:0]     hdr_len;
        logic [16:0]     offset;
        logic [4:0]      kidx;
        logic [63:0]     word;
        res.data      = b;
        res.last      = last;
        res.scrambled = 1'b0;
        case (frame_pos)
            POS_TYPE_HIGH: type_high = b;
            POS_TYPE_LOW:  is_ipv4 = (type_high == ETH_P_IP_HIGH) && (b == ETH_P_IP_LOW);
            POS_IHL:       header_words = b[3:0];
            POS_LEN_HIGH:  total_length = {b, 8'h00};
            POS_LEN_LOW:   total_length = {total_length[15:8], b};
            POS_PROTO: begin
                scramble_on = 1'b0;
                l4_len = '0;
                if (b == PROTO_NUM_TCP) begin
                    l4_len = 17'(TCP_HDR_BYTES);
                end else if (b == PROTO_NUM_UDP) begin
                    l4_len = 17'(UDP_HDR_BYTES);
                end
                hdr_len = {11'd0, header_words, 2'b00} + l4_len;
                if (is_ipv4 && header_words >= MIN_IHL && l4_len != 0
                        && {1'b0, total_length} >= hdr_len
                        && {1'b0, total_length} + 17'(ETH_HDR_BYTES) <= {1'b0, flen}) begin
                    payload_start = 17'(ETH_HDR_BYTES) + hdr_len;
                    payload_end   = 17'(ETH_HDR_BYTES) + {1'b0, total_length};
                    scramble_on   = 1'b1;
                end
            end
            default: ;
        endcase
        pos17 = {1'b0, frame_pos};
        if (scramble_on && frame_pos != POS_MAX && pos17 >= payload_start
                && pos17 < payload_end) begin
            offset = pos17 - payload_start;
            kidx   = offset[4:0];
            word   = key_words[kidx[4:3]];
            res.data      = b ^ word[8 * (7 - kidx[2:0]) +: 8];
            res.scrambled = 1'b1;
        end
        if (last) begin
            clear_frame_state();
        end else if (frame_pos != POS_MAX) begin
            frame_pos = frame_pos + 1'b1;
        end
        return res;
    endfunction

    initial begin
        mismatches = 0;
        checked    = 0;
        scrambled  = 0;
        clear_frame_state();
    end

    always @(posedge i_clk) begin
        t_scrambled_byte want;
        if (!i_rst_n) begin
            clear_frame_state();
            key_words[0] = KEY_WORD0_RST;
            key_words[1] = KEY_WORD1_RST;
            key_words[2] = KEY_WORD2_RST;
            key_words[3] = KEY_WORD3_RST;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY_WORD0: key_words[0] = i_cfg_data;
                    REG_KEY_WORD1: key_words[1] = i_cfg_data;
                    REG_KEY_WORD2: key_words[2] = i_cfg_data;
                    REG_KEY_WORD3: key_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked++;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output item: expected none, got %02h/%0b/%0b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last
                            || m_axis_tuser !== want.scrambled) begin
                        mismatches++;
                        $display("%0t: output item %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 $time, checked, want.data, want.last, want.scrambled,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                    if (want.scrambled) begin
                        scrambled++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_bytes.push_back(predict_out_byte(s_axis_tdata[7:0],
                                                          s_axis_tdata[23:8], s_axis_tlast));
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
        o_scrambled  <= scrambled;
    end

endmodule

// File: tb/sv/tb_l4_payload_xor_scrambler.sv
`timescale 1ns / 1ps

module tb_l4_payload_xor_scrambler;
    import l4pxs_pkg::*;

    localparam int PHASE_ITEMS = 50;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // frame_byte [7:0], frame_length [23:8]
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // out_byte [7:0]
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;   // out_scrambled [0]
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [KEY_WORD_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int scrambled;

    int         items_sent;
    int         frames_sent;
    int         key_settings;
    bit         calm;
    logic [7:0] frame_bytes[$];

    l4_payload_xor_scrambler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    l4pxs_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_scrambled   (scrambled)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // The receiver holds off once for a long stretch so that the block fills up.
    initial begin
        int sink_cycle;
        int hold_left;
        sink_cycle    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            sink_cycle++;
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (sink_cycle == 500) begin
                m_axis_tready <= 1'b0;
                hold_left = 299;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic [15:0] flen, input logic last);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {flen, b};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(input int flen, input bit jitter);
        logic [15:0] fl;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            fl = (jitter && i != POS_PROTO) ? 16'($urandom) : 16'(flen);
            send_item(frame_bytes[i], fl, i == frame_bytes.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic build_frame(input logic [7:0] eth_hi, eth_lo, ihl_byte, input int tot,
                               input logic [7:0] proto, input int n);
        logic [15:0] tot16;
        tot16 = 16'(tot);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom));
        if (n > POS_TYPE_HIGH) frame_bytes[POS_TYPE_HIGH] = eth_hi;
        if (n > POS_TYPE_LOW)  frame_bytes[POS_TYPE_LOW]  = eth_lo;
        if (n > POS_IHL)       frame_bytes[POS_IHL]       = ihl_byte;
        if (n > POS_LEN_HIGH)  frame_bytes[POS_LEN_HIGH]  = tot16[15:8];
        if (n > POS_LEN_LOW)   frame_bytes[POS_LEN_LOW]   = tot16[7:0];
        if (n > POS_PROTO)     frame_bytes[POS_PROTO]     = proto;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [KEY_WORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [KEY_WORD_W-1:0] w0, w1, w2, w3);
        write_reg(REG_KEY_WORD0, w0);
        write_reg(REG_KEY_WORD1, w1);
        write_reg(REG_KEY_WORD2, w2);
        write_reg(REG_KEY_WORD3, w3);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        key_settings++;
    endtask

    function automatic logic [KEY_WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed TCP or UDP frames with random content; the rest break one rule.
    task automatic random_frame();
        int         kind;
        int         ihl;
        int         hdr;
        int         tot;
        int         flen;
        int         n;
        logic [7:0] proto;
        logic [7:0] eth_hi;
        logic [7:0] eth_lo;
        bit         jitter;
        kind   = $urandom_range(0, 99);
        ihl    = ($urandom_range(0, 2) == 0) ? $urandom_range(6, 15) : 5;
        proto  = $urandom_range(0, 1) ? PROTO_NUM_TCP : PROTO_NUM_UDP;
        hdr    = ihl * 4 + ((proto == PROTO_NUM_TCP) ? 20 : 8);
        tot    = hdr + (($urandom_range(0, 7) == 0) ? $urandom_range(33, 70)
                                                    : $urandom_range(0, 32));
        eth_hi = ETH_P_IP_HIGH;
        eth_lo = ETH_P_IP_LOW;
        flen   = 14 + tot + $urandom_range(0, 6);
        n      = 14 + tot + $urandom_range(0, 4);
        jitter = ($urandom_range(0, 7) == 0);
        if (kind < 8) begin
            tot  = $urandom_range(0, hdr - 1);
            n    = 14 + hdr + $urandom_range(1, 16);
            flen = n + $urandom_range(0, 4);
        end else if (kind < 15) begin
            flen = 14 + tot - $urandom_range(1, 10);
        end else if (kind < 20) begin
            proto = 8'($urandom_range(0, 255));
            if (proto == PROTO_NUM_TCP || proto == PROTO_NUM_UDP) begin
                proto = proto ^ 8'h80;
            end
        end else if (kind < 25) begin
            ihl = $urandom_range(0, 4);
        end else if (kind < 30) begin
            eth_hi = $urandom_range(0, 1) ? ETH_P_IP_HIGH : 8'($urandom);
            eth_lo = 8'($urandom);
            if (eth_hi == ETH_P_IP_HIGH && eth_lo == ETH_P_IP_LOW) begin
                eth_lo = 8'(1 << $urandom_range(0, 7));
            end
        end else if (kind < 34) begin
            n = $urandom_range(1, 23);
        end
        build_frame(eth_hi, eth_lo, {4'($urandom), 4'(ihl)}, tot, proto, n);
        send_frame(flen, jitter);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_KEY_WORD0;
        i_cfg_data    = '0;
        items_sent    = 0;
        frames_sent   = 0;
        key_settings  = 1;
        calm          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset key.
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 45, PROTO_NUM_TCP, 59);
        send_frame(59, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 68, PROTO_NUM_UDP, 82);
        send_frame(82, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'hFF, 83, PROTO_NUM_TCP, 97);
        send_frame(100, 1'b0);
        build_frame(8'h86, 8'hDD, 8'h45, 40, PROTO_NUM_UDP, 60);
        send_frame(60, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h44, 40, PROTO_NUM_UDP, 60);
        send_frame(60, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 40, 8'd1, 60);
        send_frame(60, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 27, PROTO_NUM_UDP, 50);
        send_frame(50, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 50, PROTO_NUM_TCP, 64);
        send_frame(63, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 40, PROTO_NUM_UDP, 20);
        send_frame(0, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 40, PROTO_NUM_UDP, 54);
        send_frame(54, 1'b1);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 36, PROTO_NUM_UDP, 60);
        send_frame(50, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 28, PROTO_NUM_UDP, 44);
        send_frame(44, 1'b0);
        build_frame(ETH_P_IP_HIGH, ETH_P_IP_LOW, 8'h45, 28, PROTO_NUM_UDP, 1);
        send_frame(65535, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1:       load_key('1, '1, '1, '1);
                2:       load_key('0, '0, '0, '0);
                4:       load_key(KEY_WORD0_RST, KEY_WORD1_RST, KEY_WORD2_RST, KEY_WORD3_RST);
                default: load_key(random_word(), random_word(), random_word(), random_word());
            endcase
            calm = (ph == 2);
            begin
                int target;
                target = items_sent + PHASE_ITEMS;
                while (items_sent < target) random_frame();
            end
            wait_idle();
        end
        calm = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("Sent %0d frames (%0d bytes) under %0d key settings, broken headers included.",
                 frames_sent, items_sent, key_settings);
        $display("Checked %0d output bytes, %0d of them scrambled.", checked, scrambled);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/l4pxs_pkg.sv
rtl/l4pxs_key_regs.sv
rtl/l4pxs_hdr_track.sv
rtl/l4_payload_xor_scrambler.sv
rtl/l4pxs_checker.sv
tb/sv/l4pxs_checker.sv
tb/sv/tb_l4_payload_xor_scrambler.sv
